@@ hdl/krt_pkg.sv @@
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants for the keyed record table: request and status
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int REQ_TYPE_BITS    = 2;
   localparam int STATUS_BITS      = 3;
   localparam int ENTRY_COUNT_BITS = 5;
   localparam int REVISION_BITS    = 32;
   localparam int STATE_BITS       = 32;
   localparam int PRIORITY_BITS    = 32;
   localparam int EVIDENCE_BITS    = 64;
   localparam int KEY_PORT_BITS    = 64;
   localparam int PAYLOAD_BITS     = STATE_BITS + PRIORITY_BITS + EVIDENCE_BITS;

   // request type codes on the req_type port
   localparam logic [REQ_TYPE_BITS-1:0] REQ_FIND   = 2'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_ADD    = 2'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_REMOVE = 2'd2;

   typedef enum logic [1:0] {
      KIND_FIND,
      KIND_ADD,
      KIND_REMOVE
   } req_kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_INVALID   = 3'd1,
      STATUS_EXISTS    = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_SHIFT,
      ST_MOVE,
      ST_DONE
   } fsm_state_type;

   // controller -> datapath
   typedef struct packed {
      logic           load_req;   // capture request, clear index and find data
      logic           rd_en;      // read record at index
      logic           inc_idx;    // advance index
      logic           append;     // write request record at count, count+1, rev+1
      logic           move;       // write last read record at index-1
      logic           drop;       // count-1, rev+1
      logic           take_found; // capture read record as find data
      logic           set_result; // capture result status
      rsp_status_type result;
      logic           load_rsp;   // move result into output register
   } krt_cmd_type;

   // datapath -> controller
   typedef struct packed {
      req_kind_type kind;
      logic         key_zero;
      logic         at_end;     // index equals held count
      logic         full;
      logic         key_match;  // read record key equals request key
      logic         rsp_busy;   // output register holds a transaction not yet taken
   } krt_status_type;

endpackage

@@ hdl/krt_ram.sv @@
// ----------------------------------------------------------------------------
// krt_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module krt_ram #(
   parameter  int WIDTH     = 8,
   parameter  int DEPTH     = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/krt_ctrl.sv @@
// ----------------------------------------------------------------------------
// krt_ctrl
// Sequencer for the keyed record table: scans held records one at a time,
// decides the result, and drives the shift-down pass of a remove.
// ----------------------------------------------------------------------------
module krt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  krt_pkg::krt_status_type sts,
   output krt_pkg::krt_cmd_type    cmd
);
   import krt_pkg::*;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (sts.key_zero) begin
               // no held key is zero: add rejects, find/remove miss
               cmd.set_result = 1'b1;
               cmd.result     = (sts.kind == KIND_ADD) ? STATUS_INVALID : STATUS_NOT_FOUND;
               state_in       = ST_DONE;
            end else if (sts.at_end) begin
               cmd.set_result = 1'b1;
               if (sts.kind == KIND_ADD) begin
                  if (sts.full) begin
                     cmd.result = STATUS_FULL;
                  end else begin
                     cmd.append = 1'b1;
                     cmd.result = STATUS_OK;
                  end
               end else begin
                  cmd.result = STATUS_NOT_FOUND;
               end
               state_in = ST_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.key_match) begin
               unique case (sts.kind)
                  KIND_FIND: begin
                     cmd.take_found = 1'b1;
                     cmd.set_result = 1'b1;
                     cmd.result     = STATUS_OK;
                     state_in       = ST_DONE;
                  end
                  KIND_ADD: begin
                     cmd.set_result = 1'b1;
                     cmd.result     = STATUS_EXISTS;
                     state_in       = ST_DONE;
                  end
                  KIND_REMOVE: begin
                     cmd.inc_idx = 1'b1;
                     state_in    = ST_SHIFT;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SHIFT: begin
            if (sts.at_end) begin
               cmd.drop       = 1'b1;
               cmd.set_result = 1'b1;
               cmd.result     = STATUS_OK;
               state_in       = ST_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_MOVE;
            end
         end
         ST_MOVE: begin
            cmd.move    = 1'b1;
            cmd.inc_idx = 1'b1;
            state_in    = ST_SHIFT;
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/krt_datapath.sv @@
// ----------------------------------------------------------------------------
// krt_datapath
// Request registers, scan index, record memory, count and revision
// registers, and the response output register.
// ----------------------------------------------------------------------------
module krt_datapath #(
   parameter int TABLE_ENTRIES = 16,
   parameter int KEY_BITS      = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [krt_pkg::REQ_TYPE_BITS-1:0]       req_type,
   input  logic [krt_pkg::KEY_PORT_BITS-1:0]       req_key,
   input  logic [krt_pkg::STATE_BITS-1:0]          req_entry_state,
   input  logic [krt_pkg::PRIORITY_BITS-1:0]       req_entry_priority,
   input  logic [krt_pkg::EVIDENCE_BITS-1:0]       req_entry_evidence,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [krt_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic                                    rsp_found,
   output logic [krt_pkg::STATE_BITS-1:0]          rsp_found_state,
   output logic [krt_pkg::PRIORITY_BITS-1:0]       rsp_found_priority,
   output logic [krt_pkg::EVIDENCE_BITS-1:0]       rsp_found_evidence,
   output logic [krt_pkg::ENTRY_COUNT_BITS-1:0]    rsp_entry_count,
   output logic [krt_pkg::REVISION_BITS-1:0]       rsp_revision_count,
   input  krt_pkg::krt_cmd_type                    cmd,
   output krt_pkg::krt_status_type                 sts
);
   import krt_pkg::*;

   localparam int CNT_BITS  = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int REC_BITS  = KEY_BITS + PAYLOAD_BITS;

   // request registers
   req_kind_type                kind_ff;
   logic [KEY_BITS-1:0]         key_ff;
   logic [PAYLOAD_BITS-1:0]     payload_ff;

   // table control
   logic [CNT_BITS-1:0]         idx_ff;
   logic [CNT_BITS-1:0]         count_ff;
   logic [REVISION_BITS-1:0]    rev_ff;

   // result under construction
   rsp_status_type              result_ff;
   logic                        found_ff;
   logic [PAYLOAD_BITS-1:0]     found_data_ff;

   // output register
   logic                        rsp_valid_ff;
   rsp_status_type              rsp_status_ff;
   logic                        rsp_found_ff;
   logic [PAYLOAD_BITS-1:0]     rsp_data_ff;
   logic [ENTRY_COUNT_BITS-1:0] rsp_count_ff;
   logic [REVISION_BITS-1:0]    rsp_rev_ff;

   // memory ports
   logic                        wr_en;
   logic [ADDR_BITS-1:0]        wr_addr;
   logic [REC_BITS-1:0]         wr_data;
   logic [REC_BITS-1:0]         rd_data;
   logic [CNT_BITS-1:0]         idx_prev;
   req_kind_type                kind_in;

   always_comb begin
      if (req_type == REQ_ADD) begin
         kind_in = KIND_ADD;
      end else if (req_type == REQ_REMOVE) begin
         kind_in = KIND_REMOVE;
      end else begin
         kind_in = KIND_FIND;   // type three behaves as find
      end
   end

   assign idx_prev = idx_ff - CNT_BITS'(1);
   assign wr_en    = cmd.append | cmd.move;
   assign wr_addr  = cmd.append ? count_ff[ADDR_BITS-1:0] : idx_prev[ADDR_BITS-1:0];
   assign wr_data  = cmd.append ? {key_ff, payload_ff} : rd_data;

   krt_ram #(
      .WIDTH (REC_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_records (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   // request capture and scan index
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff    <= kind_in;
         key_ff     <= req_key[KEY_BITS-1:0];
         payload_ff <= {req_entry_state, req_entry_priority, req_entry_evidence};
      end
      if (cmd.load_req) begin
         idx_ff <= '0;
      end else if (cmd.inc_idx) begin
         idx_ff <= idx_ff + CNT_BITS'(1);
      end
      if (cmd.set_result) begin
         result_ff <= cmd.result;
      end
      if (cmd.take_found) begin
         found_data_ff <= rd_data[PAYLOAD_BITS-1:0];
      end else if (cmd.load_req) begin
         found_data_ff <= '0;
      end
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rev_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.append) begin
            count_ff <= count_ff + CNT_BITS'(1);
         end else if (cmd.drop) begin
            count_ff <= count_ff - CNT_BITS'(1);
         end
         if (cmd.append || cmd.drop) begin
            rev_ff <= rev_ff + REVISION_BITS'(1);
         end
         if (cmd.load_req) begin
            found_ff <= 1'b0;
         end else if (cmd.take_found) begin
            found_ff <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= result_ff;
         rsp_found_ff  <= found_ff;
         rsp_data_ff   <= found_data_ff;
         rsp_count_ff  <= ENTRY_COUNT_BITS'(count_ff);
         rsp_rev_ff    <= rev_ff;
      end
   end

   assign sts.kind      = kind_ff;
   assign sts.key_zero  = (key_ff == '0);
   assign sts.at_end    = (idx_ff == count_ff);
   assign sts.full      = (count_ff == CNT_BITS'(TABLE_ENTRIES));
   assign sts.key_match = (rd_data[REC_BITS-1 -: KEY_BITS] == key_ff);
   assign sts.rsp_busy  = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_state    = rsp_data_ff[PAYLOAD_BITS-1 -: STATE_BITS];
   assign rsp_found_priority = rsp_data_ff[EVIDENCE_BITS +: PRIORITY_BITS];
   assign rsp_found_evidence = rsp_data_ff[EVIDENCE_BITS-1:0];
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_revision_count = rsp_rev_ff;

endmodule

@@ hdl/keyed_record_table.sv @@
// ----------------------------------------------------------------------------
// keyed_record_table
// Bounded key/value table with find, add and remove-with-compaction.
// ----------------------------------------------------------------------------
// The table holds up to TABLE_ENTRIES records, each a nonzero key (low
// KEY_BITS bits of req_key) with state, priority and evidence values, kept in
// insertion order in a single memory. Every request transaction returns one
// response transaction carrying status, find data, entry count and the
// wrapping revision count. One request is processed at a time; the scan reads
// one record at a time through the memory's single registered read port, and
// a remove adds a shift-down pass that moves each record behind the removed
// one down by one place.
// A finished response waits in an output register, so a new request is
// accepted while the previous response is still pending.
// ----------------------------------------------------------------------------
module keyed_record_table #(
   parameter int TABLE_ENTRIES = 16,
   parameter int KEY_BITS      = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [krt_pkg::REQ_TYPE_BITS-1:0]    req_type,
   input  logic [krt_pkg::KEY_PORT_BITS-1:0]    req_key,
   input  logic [krt_pkg::STATE_BITS-1:0]       req_entry_state,
   input  logic [krt_pkg::PRIORITY_BITS-1:0]    req_entry_priority,
   input  logic [krt_pkg::EVIDENCE_BITS-1:0]    req_entry_evidence,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [krt_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic                                 rsp_found,
   output logic [krt_pkg::STATE_BITS-1:0]       rsp_found_state,
   output logic [krt_pkg::PRIORITY_BITS-1:0]    rsp_found_priority,
   output logic [krt_pkg::EVIDENCE_BITS-1:0]    rsp_found_evidence,
   output logic [krt_pkg::ENTRY_COUNT_BITS-1:0] rsp_entry_count,
   output logic [krt_pkg::REVISION_BITS-1:0]    rsp_revision_count
);
   import krt_pkg::*;

   krt_cmd_type    cmd;
   krt_status_type sts;

   // sequencer: scan, decide, shift-down, hand result to output register
   krt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // record memory, counters and output register
   krt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_BITS      (KEY_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_type           (req_type),
      .req_key            (req_key),
      .req_entry_state    (req_entry_state),
      .req_entry_priority (req_entry_priority),
      .req_entry_evidence (req_entry_evidence),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_found_state    (rsp_found_state),
      .rsp_found_priority (rsp_found_priority),
      .rsp_found_evidence (rsp_found_evidence),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_revision_count (rsp_revision_count),
      .cmd                (cmd),
      .sts                (sts)
   );

   // a find hit always reports success
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STATUS_OK)
      else $error("found response without ok status");

   // without a hit the find data fields are zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
         rsp_found_state == '0 && rsp_found_priority == '0 && rsp_found_evidence == '0)
      else $error("find data nonzero without a hit");

   // an accepted request keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // the table never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sts.full |-> !cmd.append)
      else $error("append into full table");

endmodule
